// ----- rtl/cllt_pkg.sv -----
// shared types and constants of the c-like tokenizer
// token kinds, error codes, transfer payloads and keyword lookup; no dependencies
package cllt_pkg;

    typedef enum logic [5:0] {
        K_END       = 6'd0,  K_ERROR     = 6'd1,  K_LPAREN    = 6'd2,  K_RPAREN    = 6'd3,
        K_LBRACE    = 6'd4,  K_RBRACE    = 6'd5,  K_LBRACKET  = 6'd6,  K_RBRACKET  = 6'd7,
        K_SEMI      = 6'd8,  K_COLON     = 6'd9,  K_COMMA     = 6'd10, K_DOT       = 6'd11,
        K_PLUS      = 6'd12, K_DPLUS     = 6'd13, K_PLUSEQ    = 6'd14, K_MINUS     = 6'd15,
        K_DMINUS    = 6'd16, K_MINUSEQ   = 6'd17, K_STAR      = 6'd18, K_DSTAR     = 6'd19,
        K_STAREQ    = 6'd20, K_DSTAREQ   = 6'd21, K_SLASH     = 6'd22, K_SLASHEQ   = 6'd23,
        K_PERCENT   = 6'd24, K_PERCENTEQ = 6'd25, K_ASSIGN    = 6'd26, K_EQEQ      = 6'd27,
        K_NOT       = 6'd28, K_NOTEQ     = 6'd29, K_GT        = 6'd30, K_GTEQ      = 6'd31,
        K_LT        = 6'd32, K_LTEQ      = 6'd33, K_QUEST     = 6'd34, K_IF        = 6'd35,
        K_ELSE      = 6'd36, K_FOR       = 6'd37, K_WHILE     = 6'd38, K_RETURN    = 6'd39,
        K_BREAK     = 6'd40, K_CONTINUE  = 6'd41, K_DEFAULT   = 6'd42, K_SWITCH    = 6'd43,
        K_CASE      = 6'd44, K_INT       = 6'd45, K_FLOAT     = 6'd46, K_FIXED     = 6'd47,
        K_BOOLEAN   = 6'd48, K_CHAR      = 6'd49, K_STRINGKW  = 6'd50, K_BOOLLIT   = 6'd51,
        K_NULL      = 6'd52, K_FUNC      = 6'd53, K_VOID      = 6'd54, K_CLASS     = 6'd55,
        K_STRUCT    = 6'd56, K_IDENT     = 6'd57, K_STRLIT    = 6'd58, K_CHARLIT   = 6'd59,
        K_INTLIT    = 6'd60, K_REALLIT   = 6'd61
    } tok_kind_t;

    localparam logic [2:0] E_OK        = 3'd0;
    localparam logic [2:0] E_UNEXPECT  = 3'd1;
    localparam logic [2:0] E_OPEN_STR  = 3'd2;
    localparam logic [2:0] E_BAD_ESC   = 3'd3;
    localparam logic [2:0] E_OPEN_CHAR = 3'd4;
    localparam logic [2:0] E_INT_OVF   = 3'd5;
    localparam logic [2:0] E_OPEN_CMT  = 3'd6;

    localparam logic [15:0] OUT_LINE_MAX = 16'hFFFF;
    localparam logic [11:0] OUT_COL_MAX  = 12'hFFF;
    localparam logic [63:0] INT_TOP      = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] start_line;
        logic [11:0] start_column;
        logic [15:0] token_length;
        logic [2:0]  error_code;
        logic        last;
    } out_item_t;

    // key holds the identifier text right aligned, upper bytes zero
    function automatic tok_kind_t kw_kind(logic [63:0] key);
        tok_kind_t k;
        k = K_IDENT;
        case (key)
            64'("if"):       k = K_IF;
            64'("else"):     k = K_ELSE;
            64'("for"):      k = K_FOR;
            64'("while"):    k = K_WHILE;
            64'("return"):   k = K_RETURN;
            64'("break"):    k = K_BREAK;
            64'("continue"): k = K_CONTINUE;
            64'("default"):  k = K_DEFAULT;
            64'("switch"):   k = K_SWITCH;
            64'("case"):     k = K_CASE;
            64'("int"):      k = K_INT;
            64'("float"):    k = K_FLOAT;
            64'("fixed"):    k = K_FIXED;
            64'("boolean"):  k = K_BOOLEAN;
            64'("char"):     k = K_CHAR;
            64'("string"):   k = K_STRINGKW;
            64'("true"):     k = K_BOOLLIT;
            64'("false"):    k = K_BOOLLIT;
            64'("null"):     k = K_NULL;
            64'("func"):     k = K_FUNC;
            64'("void"):     k = K_VOID;
            64'("class"):    k = K_CLASS;
            64'("struct"):   k = K_STRUCT;
            default:         k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/cllt_stream_if.sv -----
// valid/ready channel carrying one payload per transfer
// payload type is set per instance; used with cllt_pkg item types
interface cllt_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/c_like_lexical_tokenizer.sv -----
// c-like lexical tokenizer top level: byte scanner plus four-entry result queue
// depends on cllt_pkg and cllt_stream_if
//
// Takes one source byte per cycle and emits tokens with kind, start line and
// column, and length; comments and whitespace give nothing. Each input transfer
// is scanned in the cycle it is accepted and its results, at most two, are written
// into a four-entry result queue, so the block accepts a byte every cycle while
// the queue has two free entries. Results leave one per cycle while out_ch is ready;
// an item that yields two results therefore needs two output transfers. An end item
// (or a zero byte) flushes the pending token, emits END and returns to reset.
module c_like_lexical_tokenizer #(
    parameter int KEYWORD_CHARS = 8,
    parameter int LINE_BITS     = 16,
    parameter int COLUMN_BITS   = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    cllt_stream_if.sink   in_ch,
    cllt_stream_if.source out_ch
);
    import cllt_pkg::*;

    localparam int KIDX = $clog2(KEYWORD_CHARS);

    typedef enum logic [4:0] {
        S_IDLE, S_PLUS, S_MINUS, S_PERCENT, S_EQ, S_BANG, S_GT, S_LT,
        S_STAR, S_STAR2, S_SLASH, S_IDENT, S_INT, S_FRAC, S_EXP, S_EXPDIG,
        S_STRING, S_CH_OPEN, S_CH_ESC, S_CH_CLOSE, S_LINE_CMT, S_BLK_CMT,
        S_BLK_STAR
    } scan_t;

    scan_t                  state_reg, state_next;
    logic [LINE_BITS-1:0]   line_reg, line_next, tsl_reg, tsl_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next, tsc_reg, tsc_next;
    logic [15:0]            len_reg, len_next;
    logic [7:0]             kw_reg [KEYWORD_CHARS];
    logic [7:0]             kw_next [KEYWORD_CHARS];
    logic [63:0]            ival_reg, ival_next;
    logic                   ovf_reg, ovf_next;
    logic                   halted_reg, halted_next;

    out_item_t              fifo_reg [4];
    logic [1:0]             wp_reg, rp_reg;
    logic [2:0]             cnt_reg;

    function automatic out_item_t mk(logic [5:0] k, logic [LINE_BITS-1:0] l,
                                     logic [COLUMN_BITS-1:0] c, logic [15:0] n,
                                     logic [2:0] e);
        out_item_t r;
        r.token_kind   = k;
        r.start_line   = (l > LINE_BITS'(OUT_LINE_MAX)) ? OUT_LINE_MAX : 16'(l);
        r.start_column = (c > COLUMN_BITS'(OUT_COL_MAX)) ? OUT_COL_MAX : 12'(c);
        r.token_length = n;
        r.error_code   = e;
        r.last         = 1'b0;
        return r;
    endfunction

    logic       acc, is_end;
    logic [7:0] c;
    logic       is_dig, is_alp, is_sp, esc_ok;
    logic [15:0] len_inc;
    logic [67:0] dec_sum;
    logic [63:0] packed_kw, kw_key;
    logic [6:0]  shamt;

    assign acc    = in_ch.valid && in_ch.ready;
    assign c      = in_ch.payload.data_byte;
    assign is_end = in_ch.payload.func || (c == 8'd0);
    assign is_dig = (c >= "0") && (c <= "9");
    assign is_alp = (c == "_") || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    assign is_sp  = (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B)
                 || (c == 8'h0C) || (c == 8'h0D);
    assign esc_ok = (c == 8'h27) || (c == 8'h22) || (c == "?") || (c == 8'h5C)
                 || (c == "a") || (c == "b") || (c == "f") || (c == "n")
                 || (c == "r") || (c == "t") || (c == "v");
    assign len_inc = (len_reg == 16'hFFFF) ? len_reg : len_reg + 16'd1;
    assign dec_sum = {ival_reg, 3'b000} + {2'b00, ival_reg, 1'b0} + 68'(c - "0");

    // keyword key: first bytes of the identifier, right aligned
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            packed_kw[63 - 8*i -: 8] = kw_reg[i];
        end
        shamt  = 7'd64 - {len_reg[3:0], 3'b000};
        kw_key = packed_kw >> shamt;
    end

    // closing of the pending token
    logic       fin_v;
    logic [5:0] fin_kind;
    logic [2:0] fin_err;
    always_comb
    begin
        fin_v    = 1'b1;
        fin_kind = K_ERROR;
        fin_err  = E_OK;
        unique case (state_reg)
            S_PLUS:    fin_kind = K_PLUS;
            S_MINUS:   fin_kind = K_MINUS;
            S_PERCENT: fin_kind = K_PERCENT;
            S_EQ:      fin_kind = K_ASSIGN;
            S_BANG:    fin_kind = K_NOT;
            S_GT:      fin_kind = K_GT;
            S_LT:      fin_kind = K_LT;
            S_STAR:    fin_kind = K_STAR;
            S_STAR2:   fin_kind = K_DSTAR;
            S_SLASH:   fin_kind = K_SLASH;
            S_IDENT:   fin_kind = (len_reg > 16'd8) ? K_IDENT : kw_kind(kw_key);
            S_INT:
            begin
                if (ovf_reg) fin_err = E_INT_OVF;
                else         fin_kind = K_INTLIT;
            end
            S_FRAC, S_EXP, S_EXPDIG: fin_kind = K_REALLIT;
            S_STRING:              fin_err = E_OPEN_STR;
            S_CH_OPEN, S_CH_CLOSE: fin_err = E_OPEN_CHAR;
            S_CH_ESC:              fin_err = E_BAD_ESC;
            S_BLK_CMT, S_BLK_STAR: fin_err = E_OPEN_CMT;
            default:               fin_v = 1'b0;
        endcase
    end

    out_item_t r0, r1;
    logic      r0_v, r1_v;
    logic      fall;
    out_item_t fin_item;

    assign fin_item = mk((fin_err != E_OK) ? 6'(K_ERROR) : fin_kind, tsl_reg, tsc_reg,
                         (fin_err != E_OK) ? 16'd0 : len_reg, fin_err);

    always_comb
    begin
        state_next  = state_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        tsl_next    = tsl_reg;
        tsc_next    = tsc_reg;
        len_next    = len_reg;
        kw_next     = kw_reg;
        ival_next   = ival_reg;
        ovf_next    = ovf_reg;
        halted_next = halted_reg;
        r0_v = 1'b0;
        r1_v = 1'b0;
        r0   = fin_item;
        r1   = fin_item;
        fall = 1'b0;
        if (acc && is_end)
        begin
            if (!halted_reg && fin_v)
            begin
                r0_v = 1'b1;
                r1_v = 1'b1;
                r1   = mk(K_END, line_reg, col_reg, 16'd0, E_OK);
            end
            else
            begin
                r0_v = 1'b1;
                r0   = mk(K_END, line_reg, col_reg, 16'd0, E_OK);
            end
            state_next  = S_IDLE;
            line_next   = LINE_BITS'(1);
            col_next    = COLUMN_BITS'(1);
            tsl_next    = LINE_BITS'(1);
            tsc_next    = COLUMN_BITS'(1);
            len_next    = 16'd0;
            for (int i = 0; i < KEYWORD_CHARS; i++)
            begin
                kw_next[i] = 8'd0;
            end
            ival_next   = 64'd0;
            ovf_next    = 1'b0;
            halted_next = 1'b0;
        end
        else if (acc && !halted_reg)
        begin
            fall = 1'b1;
            case (state_reg)
                S_PLUS, S_MINUS, S_PERCENT, S_EQ, S_BANG, S_GT, S_LT:
                begin
                    if (state_reg == S_PLUS && c == "+")
                    begin
                        fall = 1'b0; r0_v = 1'b1;
                        r0 = mk(K_DPLUS, tsl_reg, tsc_reg, len_inc, E_OK);
                    end
                    else if (state_reg == S_MINUS && c == "-")
                    begin
                        fall = 1'b0; r0_v = 1'b1;
                        r0 = mk(K_DMINUS, tsl_reg, tsc_reg, len_inc, E_OK);
                    end
                    else if (c == "=")
                    begin
                        fall = 1'b0; r0_v = 1'b1;
                        r0 = mk(6'(fin_kind + 6'((state_reg == S_PLUS)
                                || (state_reg == S_MINUS) ? 2 : 1)),
                                tsl_reg, tsc_reg, len_inc, E_OK);
                    end
                    if (!fall)
                    begin
                        len_next   = len_inc;
                        state_next = S_IDLE;
                    end
                end
                S_STAR:
                begin
                    if (c == "*")
                    begin
                        fall = 1'b0; len_next = len_inc; state_next = S_STAR2;
                    end
                    else if (c == "=")
                    begin
                        fall = 1'b0; len_next = len_inc; state_next = S_IDLE; r0_v = 1'b1;
                        r0 = mk(K_STAREQ, tsl_reg, tsc_reg, len_inc, E_OK);
                    end
                end
                S_STAR2:
                begin
                    if (c == "=")
                    begin
                        fall = 1'b0; len_next = len_inc; state_next = S_IDLE; r0_v = 1'b1;
                        r0 = mk(K_DSTAREQ, tsl_reg, tsc_reg, len_inc, E_OK);
                    end
                end
                S_SLASH:
                begin
                    if (c == "/")
                    begin
                        fall = 1'b0; state_next = S_LINE_CMT;
                    end
                    else if (c == "*")
                    begin
                        fall = 1'b0; state_next = S_BLK_CMT;
                    end
                    else if (c == "=")
                    begin
                        fall = 1'b0; len_next = len_inc; state_next = S_IDLE; r0_v = 1'b1;
                        r0 = mk(K_SLASHEQ, tsl_reg, tsc_reg, len_inc, E_OK);
                    end
                end
                S_IDENT:
                begin
                    if (is_alp || is_dig)
                    begin
                        fall = 1'b0;
                        if (len_reg < 16'(KEYWORD_CHARS))
                        begin
                            kw_next[len_reg[KIDX-1:0]] = c;
                        end
                        len_next = len_inc;
                    end
                end
                S_INT:
                begin
                    if (is_dig)
                    begin
                        fall = 1'b0;
                        if (!ovf_reg)
                        begin
                            if (dec_sum > 68'(INT_TOP)) ovf_next = 1'b1;
                            else                        ival_next = dec_sum[63:0];
                        end
                        len_next = len_inc;
                    end
                    else if (c == ".")
                    begin
                        fall = 1'b0; len_next = len_inc; state_next = S_FRAC;
                    end
                    else if (c == "e" || c == "E")
                    begin
                        fall = 1'b0; len_next = len_inc; state_next = S_EXP;
                    end
                end
                S_FRAC:
                begin
                    if (is_dig)
                    begin
                        fall = 1'b0; len_next = len_inc;
                    end
                    else if (c == "e" || c == "E")
                    begin
                        fall = 1'b0; len_next = len_inc; state_next = S_EXP;
                    end
                end
                S_EXP:
                begin
                    if (c == "+" || c == "-" || is_dig)
                    begin
                        fall = 1'b0; len_next = len_inc; state_next = S_EXPDIG;
                    end
                end
                S_EXPDIG:
                begin
                    if (is_dig)
                    begin
                        fall = 1'b0; len_next = len_inc;
                    end
                end
                S_STRING:
                begin
                    fall = 1'b0;
                    if (c == 8'h22)
                    begin
                        state_next = S_IDLE; r0_v = 1'b1;
                        r0 = mk(K_STRLIT, tsl_reg, tsc_reg, len_reg, E_OK);
                    end
                    else
                    begin
                        len_next = len_inc;
                    end
                end
                S_CH_OPEN:
                begin
                    fall = 1'b0; len_next = len_inc;
                    state_next = (c == 8'h5C) ? S_CH_ESC : S_CH_CLOSE;
                end
                S_CH_ESC:
                begin
                    if (esc_ok)
                    begin
                        fall = 1'b0; len_next = len_inc; state_next = S_CH_CLOSE;
                    end
                end
                S_CH_CLOSE:
                begin
                    if (c == 8'h27)
                    begin
                        fall = 1'b0; state_next = S_IDLE; r0_v = 1'b1;
                        r0 = mk(K_CHARLIT, tsl_reg, tsc_reg, len_reg, E_OK);
                    end
                end
                S_LINE_CMT:
                begin
                    if (c != 8'h0A) fall = 1'b0;
                end
                S_BLK_CMT:
                begin
                    fall = 1'b0;
                    if (c == "*") state_next = S_BLK_STAR;
                end
                S_BLK_STAR:
                begin
                    fall = 1'b0;
                    if (c == "/")      state_next = S_IDLE;
                    else if (c != "*") state_next = S_BLK_CMT;
                end
                default: fall = 1'b1;
            endcase

            if (fall)
            begin
                state_next = S_IDLE;
                r0_v       = fin_v;
                if (fin_v && fin_err != E_OK)
                begin
                    halted_next = 1'b1;
                end
                else
                begin
                    // byte starts a new token
                    tsl_next = line_reg;
                    tsc_next = col_reg;
                    len_next = 16'd1;
                    r1       = mk(K_ERROR, line_reg, col_reg, 16'd1, E_OK);
                    r1_v     = 1'b0;
                    if (!is_sp)
                    begin
                        r1_v = 1'b1;
                        case (c)
                            "(": r1.token_kind = K_LPAREN;
                            ")": r1.token_kind = K_RPAREN;
                            "{": r1.token_kind = K_LBRACE;
                            "}": r1.token_kind = K_RBRACE;
                            "[": r1.token_kind = K_LBRACKET;
                            "]": r1.token_kind = K_RBRACKET;
                            ";": r1.token_kind = K_SEMI;
                            ":": r1.token_kind = K_COLON;
                            ",": r1.token_kind = K_COMMA;
                            ".": r1.token_kind = K_DOT;
                            "?": r1.token_kind = K_QUEST;
                            "+": begin r1_v = 1'b0; state_next = S_PLUS;    end
                            "-": begin r1_v = 1'b0; state_next = S_MINUS;   end
                            "%": begin r1_v = 1'b0; state_next = S_PERCENT; end
                            "=": begin r1_v = 1'b0; state_next = S_EQ;      end
                            "!": begin r1_v = 1'b0; state_next = S_BANG;    end
                            ">": begin r1_v = 1'b0; state_next = S_GT;      end
                            "<": begin r1_v = 1'b0; state_next = S_LT;      end
                            "*": begin r1_v = 1'b0; state_next = S_STAR;    end
                            "/": begin r1_v = 1'b0; state_next = S_SLASH;   end
                            8'h22:
                            begin
                                r1_v = 1'b0; len_next = 16'd0; state_next = S_STRING;
                            end
                            8'h27:
                            begin
                                r1_v = 1'b0; len_next = 16'd0; state_next = S_CH_OPEN;
                            end
                            default:
                            begin
                                if (is_alp)
                                begin
                                    r1_v = 1'b0; kw_next[0] = c; state_next = S_IDENT;
                                end
                                else if (is_dig)
                                begin
                                    r1_v = 1'b0; ival_next = 64'(c - "0");
                                    ovf_next = 1'b0; state_next = S_INT;
                                end
                                else
                                begin
                                    len_next    = 16'd0;
                                    halted_next = 1'b1;
                                    r1 = mk(K_ERROR, line_reg, col_reg, 16'd0, E_UNEXPECT);
                                end
                            end
                        endcase
                    end
                    // pack into the first free slot
                    if (!r0_v)
                    begin
                        r0   = r1;
                        r0_v = r1_v;
                        r1_v = 1'b0;
                    end
                end
            end

            if (c == 8'h0A)
            begin
                if (line_reg != '1) line_next = line_reg + LINE_BITS'(1);
                col_next = COLUMN_BITS'(1);
            end
            else if (col_reg != '1)
            begin
                col_next = col_reg + COLUMN_BITS'(1);
            end
        end
        r0.last = !r1_v;
        r1.last = 1'b1;
    end

    // result queue
    logic       pop;
    logic [2:0] nw;
    assign pop            = out_ch.valid && out_ch.ready;
    assign nw             = {2'b00, r0_v} + {2'b00, r1_v};
    assign in_ch.ready    = (cnt_reg <= 3'd2);
    assign out_ch.valid   = (cnt_reg != 3'd0);
    assign out_ch.payload = fifo_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (r0_v) fifo_reg[wp_reg] <= r0;
        if (r1_v) fifo_reg[wp_reg + 2'd1] <= r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            line_reg   <= LINE_BITS'(1);
            col_reg    <= COLUMN_BITS'(1);
            tsl_reg    <= LINE_BITS'(1);
            tsc_reg    <= COLUMN_BITS'(1);
            len_reg    <= 16'd0;
            for (int i = 0; i < KEYWORD_CHARS; i++)
            begin
                kw_reg[i] <= 8'd0;
            end
            ival_reg   <= 64'd0;
            ovf_reg    <= 1'b0;
            halted_reg <= 1'b0;
            wp_reg     <= 2'd0;
            rp_reg     <= 2'd0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            state_reg  <= state_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            tsl_reg    <= tsl_next;
            tsc_reg    <= tsc_next;
            len_reg    <= len_next;
            kw_reg     <= kw_next;
            ival_reg   <= ival_next;
            ovf_reg    <= ovf_next;
            halted_reg <= halted_next;
            wp_reg     <= wp_reg + nw[1:0];
            rp_reg     <= rp_reg + {1'b0, pop};
            cnt_reg    <= cnt_reg + nw - {2'b00, pop};
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("result queue overfilled");

    a_halt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> state_reg == S_IDLE)
        else $error("halted while a token is open");

    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !is_end && ((r0_v && r0.token_kind == K_ERROR)
                            || (r1_v && r1.token_kind == K_ERROR))) |=> halted_reg)
        else $error("error transfer without halt");

endmodule
